// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl controller dca_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DCA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");
`define DCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define DCA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define DCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/dca_pkg.sv =====
// shared types and constants of the distance correlation averager
`default_nettype none
package dca_pkg;
	localparam int ACC_W = 56;
	localparam int DIV_CNT_W = 6;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(ACC_W - 1);

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_PAIR = 2'd1;
	localparam logic [1:0] OP_EMIT = 2'd2;
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam logic [1:0] CFG_NUM_SITES = 2'd0;
	localparam logic [1:0] CFG_MARGIN = 2'd1;

	typedef struct packed {
		logic acc_rd;
		logic acc_wr;
		logic acc_clr;
		logic d_init;
		logic d_inc;
		logic div_init;
		logic div_step;
		logic out_load;
		logic out_err;
	} dca_cmd_t;

	typedef struct packed {
		logic pair_ok;
		logic len_short;
		logic d_last;
		logic div_done;
	} dca_stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/dca_ctrl.sv =====
// controller state machine of the distance correlation averager
`default_nettype none
`include "assert_macros.svh"
module dca_ctrl import dca_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire logic [1:0] op,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire dca_stat_t stat,
	output dca_cmd_t       cmd
);
	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_MUL    = 8'b0000_0010,
		S_ACC    = 8'b0000_0100,
		S_ESTART = 8'b0000_1000,
		S_ERD    = 8'b0001_0000,
		S_EPREP  = 8'b0010_0000,
		S_EDIV   = 8'b0100_0000,
		S_EOUT   = 8'b1000_0000
	} state_t;

	state_t state_q, state_nx;
	logic   err_q, err_nx;
	logic   out_valid_q;
	logic   in_fire;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		err_nx   = err_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && op == OP_PAIR && stat.pair_ok) begin
					state_nx = S_MUL;
				end else if (in_fire && op == OP_EMIT) begin
					state_nx = S_ESTART;
				end
			end
			S_MUL: begin
				state_nx = S_ACC;
			end
			S_ACC: begin
				cmd.acc_wr = 1'b1;
				state_nx   = S_IDLE;
			end
			S_ESTART: begin
				err_nx = stat.len_short;
				if (stat.len_short) begin
					state_nx = S_EOUT;
				end else begin
					cmd.d_init = 1'b1;
					state_nx   = S_ERD;
				end
			end
			S_ERD: begin
				cmd.acc_rd = 1'b1;
				state_nx   = S_EPREP;
			end
			S_EPREP: begin
				cmd.div_init = 1'b1;
				state_nx     = S_EDIV;
			end
			S_EDIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_nx = S_EOUT;
				end
			end
			S_EOUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_err  = err_q;
					if (err_q || stat.d_last) begin
						cmd.acc_clr = 1'b1;
						state_nx    = S_IDLE;
					end else begin
						cmd.d_inc = 1'b1;
						state_nx  = S_ERD;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			err_q   <= err_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// never overwrite an item still waiting at the output
	`DCA_ASSERT_IMPL(a_out_no_overwrite, clk, arst_n, cmd.out_load, out_free)
	// accumulator update comes in the state right after the multiply state
	`DCA_ASSERT_IMPL(a_acc_wr_after_mul, clk, arst_n, cmd.acc_wr, $past(state_q == S_MUL))
	// the divider never runs while new items are taken
	`DCA_ASSERT_IMPL(a_no_step_when_ready, clk, arst_n, in_ready, !cmd.div_step)
	// an error result always ends the emit run
	`DCA_ASSERT_NEXT(a_err_ends_run, clk, arst_n, cmd.out_load && cmd.out_err, in_ready)
endmodule
`default_nettype wire

// ===== hw/rtl/dca_dp.sv =====
// datapath: config, occupation store, accumulators, multiplier, divider, output register
`default_nettype none
module dca_dp import dca_pkg::*; #(
	parameter int MAX_SITES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [5:0]  cfg_data,
	input  wire logic        in_fire,
	input  wire logic [1:0]  op,
	input  wire logic [4:0]  site_first,
	input  wire logic [4:0]  site_second,
	input  wire logic [31:0] value,
	input  wire dca_cmd_t    cmd,
	output dca_stat_t        stat,
	output logic [4:0]       distance,
	output logic signed [31:0] correlation,
	output logic             last,
	output logic             error
);
	localparam int AW = $clog2(MAX_SITES);
	localparam int ADEPTH = MAX_SITES - 1;
	localparam int DW = $clog2(ADEPTH);
	localparam int NLIM = (MAX_SITES < 32) ? MAX_SITES : 32;

	logic [5:0] num_sites_q;
	logic [3:0] margin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_sites_q <= 6'd32;
			margin_q    <= 4'd0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_NUM_SITES) begin
				num_sites_q <= cfg_data;
			end else if (cfg_index == CFG_MARGIN) begin
				margin_q <= cfg_data[3:0];
			end
		end
	end

	// effective lattice and borderless length
	logic [5:0]        n_eff;
	logic signed [7:0] len;
	logic signed [7:0] n_minus_m;
	logic [4:0]        pair_d;

	assign n_eff     = (num_sites_q > 6'(NLIM)) ? 6'(NLIM) : num_sites_q;
	assign len       = $signed({2'b00, n_eff}) - $signed({3'b000, margin_q, 1'b0});
	assign n_minus_m = $signed({2'b00, n_eff}) - $signed({4'b0000, margin_q});
	assign pair_d    = site_second - site_first;

	assign stat.len_short = (len < 8'sd2);
	assign stat.pair_ok = (site_first < site_second) && (site_first >= {1'b0, margin_q})
		&& !stat.len_short && ($signed({3'b000, site_second}) < n_minus_m)
		&& (int'(pair_d) <= ADEPTH);

	// occupation store, two registered read ports
	logic [31:0] occ_mem [MAX_SITES];
	logic [31:0] occ_a_q, occ_b_q;

	always_ff @(posedge clk) begin
		if (in_fire && op == OP_LOAD && int'(site_first) < MAX_SITES) begin
			occ_mem[AW'(site_first)] <= value;
		end
		if (in_fire) begin
			occ_a_q <= occ_mem[AW'(site_first)];
			occ_b_q <= occ_mem[AW'(site_second)];
		end
	end

	// pair capture and product
	logic [31:0] value_q;
	logic [DW-1:0] pidx_q;
	logic [63:0] prod_q;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			value_q <= value;
			pidx_q  <= DW'(pair_d - 5'd1);
		end
		prod_q <= occ_a_q * occ_b_q;
	end

	// emit distance counter
	logic [4:0] d_q;
	logic [5:0] len_u;

	assign len_u       = len[5:0];
	assign stat.d_last = ({1'b0, d_q} == (len_u - 6'd1));

	always_ff @(posedge clk) begin
		if (cmd.d_init) begin
			d_q <= 5'd1;
		end else if (cmd.d_inc) begin
			d_q <= d_q + 5'd1;
		end
	end

	// accumulator memory with per-entry valid bits
	logic [ACC_W-1:0] acc_mem [ADEPTH];
	logic [ADEPTH-1:0] acc_vld_q;
	logic [ACC_W-1:0] acc_raw_q;
	logic             acc_rvld_q;
	logic [ACC_W-1:0] acc_cur;
	logic [DW-1:0]    acc_raddr;
	logic [ACC_W-1:0] term;

	assign acc_raddr = cmd.acc_rd ? DW'(d_q - 5'd1) : DW'(pair_d - 5'd1);
	assign acc_cur   = acc_rvld_q ? acc_raw_q : '0;
	assign term      = ACC_W'(value_q) - ACC_W'(prod_q[63:16]);

	always_ff @(posedge clk) begin
		if (cmd.acc_wr) begin
			acc_mem[pidx_q] <= acc_cur + term;
		end
		if (in_fire || cmd.acc_rd) begin
			acc_raw_q  <= acc_mem[acc_raddr];
			acc_rvld_q <= acc_vld_q[acc_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q <= '0;
		end else if (cmd.acc_clr) begin
			acc_vld_q <= '0;
		end else if (cmd.acc_wr) begin
			acc_vld_q[pidx_q] <= 1'b1;
		end
	end

	// restoring divider on the magnitude, one quotient bit per cycle
	logic [ACC_W-1:0]     quo_q;
	logic [4:0]           rem_q;
	logic [4:0]           dvsr_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [5:0]           rem_sh;
	logic                 q_bit;
	logic [5:0]           dvsr_full;

	assign rem_sh        = {rem_q, quo_q[ACC_W-1]};
	assign q_bit         = (rem_sh >= {1'b0, dvsr_q});
	assign stat.div_done = (cnt_q == DIV_LAST);
	assign dvsr_full     = len_u - {1'b0, d_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			neg_q  <= acc_cur[ACC_W-1];
			quo_q  <= acc_cur[ACC_W-1] ? (~acc_cur + ACC_W'(1)) : acc_cur;
			rem_q  <= '0;
			dvsr_q <= dvsr_full[4:0];
			cnt_q  <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[ACC_W-2:0], q_bit};
			rem_q <= q_bit ? 5'(rem_sh - {1'b0, dvsr_q}) : rem_sh[4:0];
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
	end

	// saturation to signed Q16.16
	logic [31:0] sat;

	always_comb begin
		if (!neg_q) begin
			sat = (quo_q > ACC_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo_q[31:0];
		end else begin
			sat = (quo_q > ACC_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
				: (~quo_q[31:0] + 32'd1);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_err) begin
				distance    <= 5'd0;
				correlation <= 32'sd0;
				last        <= 1'b1;
				error       <= 1'b1;
			end else begin
				distance    <= d_q;
				correlation <= $signed(sat);
				last        <= stat.d_last;
				error       <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/distance_correlation_averager_top.sv =====
// top level of the distance correlation averager
// usage:
// - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes num_sites (index 0)
//   or margin (index 1); cfg_ready is always high, write only while idle
// - in channel (in_valid/in_ready) takes one item: op, site_first, site_second, value
//   op load stores an occupation; op pair reads both occupations, multiplies in the
//   next cycle and then updates the distance accumulator in state S_ACC, so a pair
//   item keeps the in channel not ready through states S_MUL and S_ACC
// - op emit streams results d = 1..L-1 on the out channel; each result runs the
//   shared bit-serial divider over the 56-bit accumulator: a read, a setup, then
//   the 56 divider steps and the output state
// - an emit with L below two gives a single error item; every emit clears the
//   accumulators at its final item
// - out channel is one output register; a stall on out_ready holds the item and
//   pauses the emit run, while the last item may wait as new items are taken
// - reset returns num_sites 32, margin 0, accumulators zero, channels empty;
//   the occupation store holds no defined value until loaded
`default_nettype none
module distance_correlation_averager_top import dca_pkg::*; #(
	parameter int MAX_SITES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [5:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [4:0]  site_first,
	input  wire logic [4:0]  site_second,
	input  wire logic [31:0] value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [4:0]       distance,
	output logic signed [31:0] correlation,
	output logic             last,
	output logic             error
);
	dca_cmd_t  cmd;
	dca_stat_t stat;
	logic      in_fire;
	logic      cfg_we;

	// config writes are taken at any time
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign in_fire   = in_valid && in_ready;

	// controller sequences pair updates and emit runs
	dca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath holds the data storage and all arithmetic
	dca_dp #(
		.MAX_SITES (MAX_SITES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_fire     (in_fire),
		.op          (op),
		.site_first  (site_first),
		.site_second (site_second),
		.value       (value),
		.cmd         (cmd),
		.stat        (stat),
		.distance    (distance),
		.correlation (correlation),
		.last        (last),
		.error       (error)
	);
endmodule
`default_nettype wire

// ===== tb/dca_checker.sv =====
// checker for the distance correlation averager: predicts results and compares them
`timescale 1ns / 100ps
`default_nettype none
module dca_checker import dca_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [5:0]  cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [4:0]  site_first,
	input  wire logic [4:0]  site_second,
	input  wire logic [31:0] value,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [4:0]  distance,
	input  wire logic signed [31:0] correlation,
	input  wire logic        last,
	input  wire logic        error,
	output int               fail_count,
	output int               pending
);
	typedef struct packed {
		logic [4:0] gap;
		logic [31:0] corr;
		logic lst;
		logic err;
	} corr_result_t;

	logic [5:0] sites_reg;
	logic [3:0] margin_reg;
	logic [31:0] occ [32];
	logic [55:0] dist_acc [31];
	corr_result_t awaited [$];

	// append one predicted result at the tail of the queue
	function automatic void add_awaited(input corr_result_t r);
		awaited = {awaited, r};
	endfunction

	task automatic absorb_item(input logic [1:0] o, input logic [4:0] a, input logic [4:0] b,
			input logic [31:0] v);
		int n, len, d;
		longint q, s;
		logic [63:0] prod;
		corr_result_t r;
		begin
			n = (sites_reg > 32) ? 32 : sites_reg;
			len = n - 2 * margin_reg;
			if (o == OP_LOAD) begin
				occ[a] = v;
			end else if (o == OP_PAIR) begin
				if (a < b && a >= margin_reg && len >= 2 && b < n - margin_reg) begin
					prod = ({32'd0, occ[a]} * {32'd0, occ[b]}) >> 16;
					dist_acc[b - a - 1] = dist_acc[b - a - 1] + 56'(64'(v) - prod);
				end
			end else if (o == OP_EMIT) begin
				if (len < 2) begin
					r = '{gap: 5'd0, corr: 32'd0, lst: 1'b1, err: 1'b1};
					add_awaited(r);
				end else begin
					for (d = 1; d < len; d++) begin
						s = longint'(signed'(dist_acc[d - 1]));
						q = s / (len - d);
						if (q > 64'sd2147483647) q = 64'sd2147483647;
						if (q < -64'sd2147483648) q = -64'sd2147483648;
						r = '{gap: 5'(d), corr: 32'(q), lst: (d == len - 1), err: 1'b0};
						add_awaited(r);
					end
				end
				foreach (dist_acc[i]) dist_acc[i] = '0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		corr_result_t e;
		if (!arst_n) begin
			sites_reg = 6'd32;
			margin_reg = 4'd0;
			foreach (occ[i]) occ[i] = '0;
			foreach (dist_acc[i]) dist_acc[i] = '0;
			awaited.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_NUM_SITES) sites_reg = cfg_data;
				else if (cfg_index == CFG_MARGIN) margin_reg = cfg_data[3:0];
			end
			if (in_valid && in_ready) absorb_item(op, site_first, site_second, value);
			if (out_valid && out_ready) begin
				if (awaited.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: dist %0d corr %0d last %0b err %0b",
							distance, correlation, last, error);
				end else begin
					e = awaited.pop_front();
					if (e.gap !== distance || e.corr !== correlation || e.lst !== last ||
							e.err !== error) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp d%0d c%0d l%0b e%0b, got d%0d c%0d l%0b e%0b",
								e.gap, $signed(e.corr), e.lst, e.err,
								distance, correlation, last, error);
					end
				end
			end
			pending = awaited.size();
		end
	end
endmodule
`default_nettype wire

// ===== tb/tb_distance_correlation_averager_top.sv =====
// testbench top: stimulus, flow control and verdict for the averager
`timescale 1ns / 100ps
`default_nettype none
module tb_distance_correlation_averager_top;
	import dca_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [5:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = '0;
	logic [4:0] site_first = '0;
	logic [4:0] site_second = '0;
	logic [31:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [4:0] distance;
	logic signed [31:0] correlation;
	logic last;
	logic error;
	int fail_count;
	int pending;

	// idling control shared with the sink process
	bit calm_phase = 1'b0;
	bit hold_sink = 1'b0;
	// sites loaded since reset, so pairs never read an undefined occupation
	bit loaded [32];
	int cur_sites = 32;
	int cur_margin = 0;

	distance_correlation_averager_top uut (.*);

	dca_checker chk (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// sink: random back-pressure, always ready in the calm phase, or a long hold when asked
	always @(posedge clk) begin
		if (hold_sink) out_ready <= 1'b0;
		else if (calm_phase) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(99) >= 22);
	end

	// one item on the input channel, with a random gap first outside the calm phase;
	// valid stays high after acceptance until the caller drops it or sends the next item
	task automatic send_item(input logic [1:0] o, input logic [4:0] a, input logic [4:0] b,
			input logic [31:0] v);
		while (!calm_phase && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		site_first <= a;
		site_second <= b;
		value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (o == OP_LOAD) loaded[a] = 1'b1;
	endtask

	// wait until every expected result is out, plus the divider latency
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [5:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_NUM_SITES) cur_sites = data;
		else cur_margin = data;
	endtask

	task automatic set_lattice(input int n, input int m);
		drain();
		write_reg(CFG_NUM_SITES, 6'(n));
		write_reg(CFG_MARGIN, 6'(m));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h0001_FFFF);
			2: return 32'hFFFF_FFFF - $urandom_range(255);
			default: return $urandom_range(32'h0001_0000);
		endcase
	endfunction

	// a pair that is loaded on both sites, else an ignored pair b, b; mostly inside the margins
	task automatic send_pair();
		logic [4:0] a, b;
		a = 5'($urandom_range(31));
		b = 5'($urandom_range(31));
		if ($urandom_range(9) < 8 && cur_sites - cur_margin > cur_margin + 1) begin
			a = 5'($urandom_range(cur_sites - cur_margin - 2, cur_margin));
			b = 5'($urandom_range(cur_sites - cur_margin - 1, a + 1));
		end
		if (loaded[a] && loaded[b]) send_item(OP_PAIR, a, b, rand_value());
		else send_item(OP_PAIR, b, b, rand_value()); // a == b: ignored, no update
	endtask

	initial begin
		int k;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: load every site, value extremes
		calm_phase = 1'b1;
		for (k = 0; k < 32; k++)
			send_item(OP_LOAD, 5'(k), 5'(31 - k), (k % 3 == 0) ? 32'hFFFF_FFFF :
				(k % 3 == 1) ? 32'd0 : 32'h0001_0000);
		calm_phase = 1'b0;
		send_item(OP_PAIR, 5'd0, 5'd31, 32'hFFFF_FFFF);
		send_item(OP_PAIR, 5'd0, 5'd3, 32'd0);
		send_item(OP_PAIR, 5'd0, 5'd3, 32'd0);   // repeated pair adds again
		send_item(OP_PAIR, 5'd5, 5'd4, 32'h1234); // a > b ignored
		send_item(OP_PAIR, 5'd7, 5'd7, 32'h1234); // a == b ignored
		send_item(OP_SPARE, 5'd31, 5'd31, 32'hFFFF_FFFF); // unused op
		send_item(OP_EMIT, 5'd0, 5'd0, 32'd0);
		set_lattice(2, 0);
		send_item(OP_EMIT, 5'd0, 5'd0, 32'd0); // smallest usable lattice
		set_lattice(10, 4);
		send_item(OP_EMIT, 5'd0, 5'd0, 32'd0); // margins leave L of two, no error
		set_lattice(63, 15);                   // oversized count, widest margin
		send_item(OP_PAIR, 5'd15, 5'd16, 32'h0);
		send_item(OP_EMIT, 5'd0, 5'd0, 32'd0); // L of two again, one result
		set_lattice(12, 2);
		send_item(OP_PAIR, 5'd1, 5'd5, 32'h5);  // below margin
		send_item(OP_PAIR, 5'd2, 5'd10, 32'h5); // beyond margin
		send_item(OP_PAIR, 5'd2, 5'd9, 32'hFFFF_FFFF);
		send_item(OP_EMIT, 5'd0, 5'd0, 32'd0);

		// random phases over several lattices, mostly small
		for (int ph = 0; ph < 10; ph++) begin
			case (ph % 5)
				0: set_lattice($urandom_range(6, 12), $urandom_range(0, 2));
				1: set_lattice($urandom_range(2, 63), $urandom_range(0, 15));
				2: set_lattice(32, 0);
				3: set_lattice($urandom_range(4, 8), $urandom_range(0, 1));
				default: set_lattice($urandom_range(10, 20), $urandom_range(0, 4));
			endcase
			calm_phase = (ph == 4);
			for (k = 0; k < 27; k++) begin
				case ($urandom_range(9))
					0, 1: send_item(OP_LOAD, 5'($urandom_range(31)), 5'($urandom), rand_value());
					9: send_item(OP_SPARE, 5'($urandom), 5'($urandom), $urandom);
					default: send_pair();
				endcase
			end
			calm_phase = 1'b0;
			send_item(OP_EMIT, 5'($urandom), 5'($urandom), $urandom);
			if (ph == 6) begin
				// long sink stall while emits keep coming
				hold_sink = 1'b1;
				fork
					begin
						int c;
						for (c = 0; c < 600; c++) @(posedge clk);
						hold_sink = 1'b0;
					end
					begin
						send_item(OP_EMIT, 5'd0, 5'd0, 32'd0);
						send_item(OP_EMIT, 5'd0, 5'd0, 32'd0);
						send_pair();
						in_valid <= 1'b0;
					end
				join
			end
		end

		drain();
		if (fail_count == 0) begin
			$display("distance_correlation_averager_top test passed");
		end else begin
			$display("distance_correlation_averager_top test failed");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("distance_correlation_averager_top test failed");
		$finish;
	end
endmodule
`default_nettype wire
